/* design/lif_pkg.sv */
// Shared types, register codes, reset values and arithmetic helpers for the
// leaky integrate-and-fire neuron. No dependencies.
package lif_pkg;

    localparam int unsigned MUL_A_W = 24;
    localparam int unsigned MUL_B_W = 24;
    localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W + 1;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    localparam logic [2:0] IDX_STEP_GAIN       = 3'd0;
    localparam logic [2:0] IDX_THR_DECAY_GAIN  = 3'd1;
    localparam logic [2:0] IDX_REST_POTENTIAL  = 3'd2;
    localparam logic [2:0] IDX_RESET_POTENTIAL = 3'd3;
    localparam logic [2:0] IDX_BASE_THRESHOLD  = 3'd4;
    localparam logic [2:0] IDX_PEAK_THRESHOLD  = 3'd5;
    localparam logic [2:0] IDX_REFRACT_TICKS   = 3'd6;
    localparam logic [2:0] IDX_INTEG_MODE      = 3'd7;

    localparam logic [1:0] MODE_EULER = 2'd0;
    localparam logic [1:0] MODE_RK4   = 2'd1;

    localparam logic        [15:0] RST_STEP_GAIN       = 16'd6554;
    localparam logic        [15:0] RST_THR_DECAY_GAIN  = 16'd3277;
    localparam logic signed [15:0] RST_REST_POTENTIAL  = -16'sd17920;
    localparam logic signed [15:0] RST_RESET_POTENTIAL = -16'sd17920;
    localparam logic signed [15:0] RST_BASE_THRESHOLD  = -16'sd12800;
    localparam logic signed [15:0] RST_PEAK_THRESHOLD  = 16'sd0;
    localparam logic        [15:0] RST_REFRACT_TICKS   = 16'd20;
    localparam logic        [1:0]  RST_INTEG_MODE      = MODE_EULER;

    // Division by six: floor(u / 6) = (u * DIV6_RECIP) >> DIV6_SHIFT for u < 2^23.
    localparam logic [MUL_A_W-1:0]        DIV6_RECIP  = 24'd11184811;
    localparam int unsigned               DIV6_SHIFT  = 26;
    localparam logic signed [MUL_B_W-1:0] DIV6_BIAS   = 24'sd6291456;
    localparam logic signed [MUL_B_W-1:0] DIV6_OFFSET = 24'sd1048576;

    typedef struct packed {
        logic        [15:0] step_gain;
        logic        [15:0] threshold_decay_gain;
        logic signed [15:0] rest_potential;
        logic signed [15:0] reset_potential;
        logic signed [15:0] base_threshold;
        logic signed [15:0] peak_threshold;
        logic        [15:0] refractory_ticks;
        logic        [1:0]  integrator_mode;
    } lif_cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DEC_MUL,
        ST_DEC_UPD,
        ST_K1_MUL,
        ST_K1_UPD,
        ST_K2_MUL,
        ST_K2_UPD,
        ST_K3_MUL,
        ST_K3_UPD,
        ST_K4_MUL,
        ST_K4_UPD,
        ST_DIV_MUL,
        ST_DIV_UPD,
        ST_FIRE,
        ST_OUT
    } lif_state_t;

    function automatic logic signed [15:0] sat16(input logic signed [23:0] x);
        logic signed [15:0] y;
        if (x > 24'sd32767)
        begin
            y = 16'sh7FFF;
        end
        else if (x < -24'sd32768)
        begin
            y = 16'sh8000;
        end
        else
        begin
            y = x[15:0];
        end
        return y;
    endfunction

endpackage

/* design/lif_cfg.sv */
// Configuration register file of the neuron behind an APB-style port.
// Depends on lif_pkg for the register codes, reset values and lif_cfg_t.
module lif_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lif_pkg::ADDR_W-1:0]   paddr,
    input  logic [lif_pkg::DATA_W-1:0]   pwdata,
    output logic [lif_pkg::DATA_W-1:0]   prdata,
    output lif_pkg::lif_cfg_t            cfg
);
    import lif_pkg::*;

    lif_cfg_t   cfg_reg;
    lif_cfg_t   cfg_next;
    logic [2:0] index;
    logic       write_en;

    assign index    = paddr[ADDR_W-1:2];
    assign write_en = psel && penable && pwrite;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_en)
        begin
            unique case (index)
                IDX_STEP_GAIN:       cfg_next.step_gain            = pwdata[15:0];
                IDX_THR_DECAY_GAIN:  cfg_next.threshold_decay_gain = pwdata[15:0];
                IDX_REST_POTENTIAL:  cfg_next.rest_potential       = pwdata[15:0];
                IDX_RESET_POTENTIAL: cfg_next.reset_potential      = pwdata[15:0];
                IDX_BASE_THRESHOLD:  cfg_next.base_threshold       = pwdata[15:0];
                IDX_PEAK_THRESHOLD:  cfg_next.peak_threshold       = pwdata[15:0];
                IDX_REFRACT_TICKS:   cfg_next.refractory_ticks     = pwdata[15:0];
                IDX_INTEG_MODE:      cfg_next.integrator_mode      = pwdata[1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            IDX_STEP_GAIN:       prdata = {16'd0, cfg_reg.step_gain};
            IDX_THR_DECAY_GAIN:  prdata = {16'd0, cfg_reg.threshold_decay_gain};
            IDX_REST_POTENTIAL:  prdata = {16'd0, cfg_reg.rest_potential};
            IDX_RESET_POTENTIAL: prdata = {16'd0, cfg_reg.reset_potential};
            IDX_BASE_THRESHOLD:  prdata = {16'd0, cfg_reg.base_threshold};
            IDX_PEAK_THRESHOLD:  prdata = {16'd0, cfg_reg.peak_threshold};
            IDX_REFRACT_TICKS:   prdata = {16'd0, cfg_reg.refractory_ticks};
            IDX_INTEG_MODE:      prdata = {30'd0, cfg_reg.integrator_mode};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_gain            <= RST_STEP_GAIN;
            cfg_reg.threshold_decay_gain <= RST_THR_DECAY_GAIN;
            cfg_reg.rest_potential       <= RST_REST_POTENTIAL;
            cfg_reg.reset_potential      <= RST_RESET_POTENTIAL;
            cfg_reg.base_threshold       <= RST_BASE_THRESHOLD;
            cfg_reg.peak_threshold       <= RST_PEAK_THRESHOLD;
            cfg_reg.refractory_ticks     <= RST_REFRACT_TICKS;
            cfg_reg.integrator_mode      <= RST_INTEG_MODE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* design/lif_mul.sv */
// Shared multiplier of the neuron with a registered product.
// Depends on lif_pkg for the operand and product widths.
module lif_mul (
    input  logic                                clk,
    input  logic        [lif_pkg::MUL_A_W-1:0]  a,
    input  logic signed [lif_pkg::MUL_B_W-1:0]  b,
    output logic signed [lif_pkg::PROD_W-1:0]   prod
);
    import lif_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    assign prod = prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= $signed({1'b0, a}) * b;
    end

endmodule

/* design/leaky_integrate_fire_neuron.sv */
// An item runs the DEC states, then ST_OUT if refractory, else the K1 states with
// forward Euler, K1 to K4 and DIV states with Runge-Kutta or none in other modes,
// then ST_FIRE and ST_OUT, where an output stall holds it. A new input is taken only
// back in ST_IDLE, once the result is registered. The one shared multiplier uses a MUL
// and an UPD state per product. Reset is asynchronous, active low, and restores the
// register defaults, membrane at rest, threshold at base and no refractory count.
module leaky_integrate_fire_neuron (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic        [lif_pkg::ADDR_W-1:0]   paddr,
    input  logic        [lif_pkg::DATA_W-1:0]   pwdata,
    output logic        [lif_pkg::DATA_W-1:0]   prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [15:0]                  drive,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                spiked,
    output logic signed [15:0]                  membrane_potential,
    output logic signed [15:0]                  current_threshold,
    output logic                                refractory_active
);
    import lif_pkg::*;

    localparam logic signed [PROD_W-1:0] HALF16  = 49'sd32768;
    localparam logic signed [PROD_W-1:0] HALF17  = 49'sd65536;
    localparam logic signed [PROD_W-1:0] HALF6X  = 49'sd196608;

    lif_cfg_t                   cfg;
    lif_state_t                 state_reg, state_next;
    logic signed [15:0]         mem_reg, mem_next;
    logic signed [15:0]         thr_reg, thr_next;
    logic        [15:0]         refr_left_reg, refr_left_next;
    logic signed [19:0]         d1_reg, d1_next;
    logic signed [21:0]         acc_reg, acc_next;
    logic        [MUL_A_W-1:0]  a_reg, a_next;
    logic signed [MUL_B_W-1:0]  b_reg, b_next;
    logic                       spike_reg, spike_next;
    logic                       refr_flag_reg, refr_flag_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_spiked_reg, out_spiked_next;
    logic signed [15:0]         out_mem_reg, out_mem_next;
    logic signed [15:0]         out_thr_reg, out_thr_next;
    logic                       out_refr_reg, out_refr_next;

    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   prod_r16_full;
    logic signed [PROD_W-1:0]   prod_r17_full;
    logic signed [PROD_W-1:0]   prod_r6_full;
    logic signed [23:0]         prod_r16;
    logic signed [23:0]         prod_r17;
    logic signed [23:0]         prod_r6;
    logic signed [23:0]         quot6;
    logic signed [23:0]         mem24;
    logic signed [23:0]         thr24;
    logic signed [23:0]         d1_24;
    logic signed [23:0]         dk;
    logic                       accept;
    logic                       out_ready;
    logic                       integrate;

    lif_cfg u_lif_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    lif_mul u_lif_mul (
        .clk  (clk),
        .a    (a_reg),
        .b    (b_reg),
        .prod (prod)
    );

    assign pready    = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_ready = !out_valid_reg || !out_stall;
    assign integrate = (cfg.integrator_mode == MODE_EULER) ||
                       (cfg.integrator_mode == MODE_RK4);

    assign prod_r16_full = (prod + HALF16) >>> 16;
    assign prod_r17_full = (prod + HALF17) >>> 17;
    assign prod_r6_full  = (prod + HALF6X) >>> 16;
    assign prod_r16      = prod_r16_full[23:0];
    assign prod_r17      = prod_r17_full[23:0];
    assign prod_r6       = prod_r6_full[23:0];
    assign quot6         = $signed({3'd0, prod[DIV6_SHIFT+20:DIV6_SHIFT]}) - DIV6_OFFSET;

    assign mem24 = {{8{mem_reg[15]}}, mem_reg};
    assign thr24 = {{8{thr_reg[15]}}, thr_reg};
    assign d1_24 = {{4{d1_reg[19]}}, d1_reg};

    assign out_valid          = out_valid_reg;
    assign spiked             = out_spiked_reg;
    assign membrane_potential = out_mem_reg;
    assign current_threshold  = out_thr_reg;
    assign refractory_active  = out_refr_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DEC_MUL;
                end
            end
            ST_DEC_MUL: state_next = ST_DEC_UPD;
            ST_DEC_UPD:
            begin
                if (refr_left_reg != 16'd0)
                begin
                    state_next = ST_OUT;
                end
                else if (integrate)
                begin
                    state_next = ST_K1_MUL;
                end
                else
                begin
                    state_next = ST_FIRE;
                end
            end
            ST_K1_MUL: state_next = ST_K1_UPD;
            ST_K1_UPD:
            begin
                if (cfg.integrator_mode == MODE_EULER)
                begin
                    state_next = ST_FIRE;
                end
                else
                begin
                    state_next = ST_K2_MUL;
                end
            end
            ST_K2_MUL:  state_next = ST_K2_UPD;
            ST_K2_UPD:  state_next = ST_K3_MUL;
            ST_K3_MUL:  state_next = ST_K3_UPD;
            ST_K3_UPD:  state_next = ST_K4_MUL;
            ST_K4_MUL:  state_next = ST_K4_UPD;
            ST_K4_UPD:  state_next = ST_DIV_MUL;
            ST_DIV_MUL: state_next = ST_DIV_UPD;
            ST_DIV_UPD: state_next = ST_FIRE;
            ST_FIRE:    state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        mem_next        = mem_reg;
        thr_next        = thr_reg;
        refr_left_next  = refr_left_reg;
        d1_next         = d1_reg;
        acc_next        = acc_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        spike_next      = spike_reg;
        refr_flag_next  = refr_flag_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_spiked_next = out_spiked_reg;
        out_mem_next    = out_mem_reg;
        out_thr_next    = out_thr_reg;
        out_refr_next   = out_refr_reg;
        dk              = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    d1_next = {{4{cfg.rest_potential[15]}}, cfg.rest_potential}
                            - {{4{mem_reg[15]}}, mem_reg}
                            + {{4{drive[15]}}, drive};
                    a_next  = {8'd0, cfg.threshold_decay_gain};
                    b_next  = {{8{cfg.base_threshold[15]}}, cfg.base_threshold} - thr24;
                end
            end
            ST_DEC_UPD:
            begin
                thr_next   = sat16(thr24 + prod_r16);
                spike_next = 1'b0;
                if (refr_left_reg != 16'd0)
                begin
                    refr_left_next = refr_left_reg - 16'd1;
                    mem_next       = cfg.reset_potential;
                    refr_flag_next = 1'b1;
                end
                else
                begin
                    refr_flag_next = 1'b0;
                    a_next         = {8'd0, cfg.step_gain};
                    b_next         = d1_24;
                end
            end
            ST_K1_UPD:
            begin
                if (cfg.integrator_mode == MODE_EULER)
                begin
                    mem_next = sat16(mem24 + prod_r16);
                end
                else
                begin
                    dk       = d1_24 - prod_r17;
                    b_next   = dk;
                    acc_next = 22'(d1_24 + (dk <<< 1));
                end
            end
            ST_K2_UPD:
            begin
                dk       = d1_24 - prod_r17;
                b_next   = dk;
                acc_next = 22'({{2{acc_reg[21]}}, acc_reg} + (dk <<< 1));
            end
            ST_K3_UPD:
            begin
                dk     = d1_24 - prod_r16;
                b_next = {{2{acc_reg[21]}}, acc_reg} + dk;
            end
            ST_K4_UPD:
            begin
                a_next = DIV6_RECIP;
                b_next = prod_r6 + DIV6_BIAS;
            end
            ST_DIV_UPD:
            begin
                mem_next = sat16(mem24 + quot6);
            end
            ST_FIRE:
            begin
                if (mem_reg >= thr_reg)
                begin
                    spike_next     = 1'b1;
                    mem_next       = cfg.reset_potential;
                    refr_left_next = cfg.refractory_ticks;
                    thr_next       = cfg.peak_threshold;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_spiked_next = spike_reg;
                    out_mem_next    = mem_reg;
                    out_thr_next    = thr_reg;
                    out_refr_next   = refr_flag_reg;
                end
            end
            default:
            begin
                dk = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mem_reg       <= RST_REST_POTENTIAL;
            thr_reg       <= RST_BASE_THRESHOLD;
            refr_left_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mem_reg       <= mem_next;
            thr_reg       <= thr_next;
            refr_left_reg <= refr_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d1_reg         <= d1_next;
        acc_reg        <= acc_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        spike_reg      <= spike_next;
        refr_flag_reg  <= refr_flag_next;
        out_spiked_reg <= out_spiked_next;
        out_mem_reg    <= out_mem_next;
        out_thr_reg    <= out_thr_next;
        out_refr_reg   <= out_refr_next;
    end

endmodule

/* design/lif_checker.sv */
// Port-level checks for the neuron and the bind that attaches them to it.
// Depends only on the ports of leaky_integrate_fire_neuron.
module lif_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic               spiked,
    input logic signed [15:0] membrane_potential,
    input logic signed [15:0] current_threshold,
    input logic               refractory_active
);

    // A stalled result holds its value until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(spiked) &&
        $stable(membrane_potential) && $stable(current_threshold) &&
        $stable(refractory_active))
    else $error("stalled result changed");

    // The block works on one item at a time, so an input transfer makes it busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

    // A refractory step never fires.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(spiked && refractory_active))
    else $error("spike during refractory step");

    // A new result is registered only at the end of an item's work.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
    else $error("result without a busy item");

endmodule

bind leaky_integrate_fire_neuron lif_checker u_lif_checker (.*);

/* tb/leaky_integrate_fire_neuron_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for leaky_integrate_fire_neuron: random and directed drive
// values, with a step-level model of the neuron predicting every result transfer.
// Depends on lif_pkg and the leaky_integrate_fire_neuron RTL.
module leaky_integrate_fire_neuron_test;
    import lif_pkg::*;

    localparam logic [1:0] MODE_HOLD  = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam longint     UNIT = 65536;
    localparam int         CYCLE_LIMIT = 500000;
    localparam int         SETTLE_CYCLES = 24;
    localparam int         HOLD_AFTER_ITEMS = 150;
    localparam int         HOLD_CYCLES = 400;
    localparam int         RANDOM_PHASES = 10;
    localparam int         ITEMS_PER_PHASE = 65;

    typedef struct packed {
        logic               spiked;
        logic signed [15:0] membrane;
        logic signed [15:0] threshold;
        logic               refractory;
    } step_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic        [ADDR_W-1:0]  paddr = '0;
    logic        [DATA_W-1:0]  pwdata = '0;
    logic        [DATA_W-1:0]  prdata;
    logic                      pready;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic signed [15:0]        drive = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic                      spiked;
    logic signed [15:0]        membrane_potential;
    logic signed [15:0]        current_threshold;
    logic                      refractory_active;

    logic        [15:0] cfg_step_gain = RST_STEP_GAIN;
    logic        [15:0] cfg_thr_gain = RST_THR_DECAY_GAIN;
    logic signed [15:0] cfg_rest = RST_REST_POTENTIAL;
    logic signed [15:0] cfg_reset = RST_RESET_POTENTIAL;
    logic signed [15:0] cfg_base_thr = RST_BASE_THRESHOLD;
    logic signed [15:0] cfg_peak_thr = RST_PEAK_THRESHOLD;
    logic        [15:0] cfg_ticks = RST_REFRACT_TICKS;
    logic        [1:0]  cfg_mode = RST_INTEG_MODE;

    logic signed [15:0] membrane_q = RST_REST_POTENTIAL;
    logic signed [15:0] threshold_q = RST_BASE_THRESHOLD;
    logic        [15:0] refr_left = '0;

    logic signed [15:0] drive_q [$];
    step_result_t       pending_steps [$];

    logic in_fire = 1'b0;
    int   in_gap = 0;
    int   stall_left = 0;
    int   hold_left = 0;
    logic long_hold_done = 1'b0;
    logic calm_phase = 1'b0;
    int   inputs_taken = 0;
    int   fail_count = 0;
    int   cycle_count = 0;

    leaky_integrate_fire_neuron uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .drive              (drive),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .spiked             (spiked),
        .membrane_potential (membrane_potential),
        .current_threshold  (current_threshold),
        .refractory_active  (refractory_active)
    );

    always #5 clk = ~clk;

    function automatic longint div_round(input longint num, input longint den);
        longint n;
        longint q;
        n = num + den / 2;
        q = n / den;
        if (n % den != 0 && n < 0)
        begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic logic signed [15:0] clamp16(input longint x);
        if (x > 32767)
        begin
            return 16'sh7FFF;
        end
        if (x < -32768)
        begin
            return 16'sh8000;
        end
        return 16'(x);
    endfunction

    function automatic int idle_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [15:0] edge_value();
        case ($urandom_range(0, 4))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h7FFF;
            3: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] random_drive(input bit wild);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (wild || r < 10)
        begin
            return 16'($urandom);
        end
        else if (r < 14)
        begin
            return r[0] ? 16'h7FFF : 16'h8000;
        end
        return 16'($urandom_range(0, 12800));
    endfunction

    task automatic advance_neuron(input logic signed [15:0] drv, output step_result_t res);
        longint gain;
        longint d1;
        longint d2;
        longint d3;
        longint d4;
        longint weighted;
        gain = longint'(cfg_step_gain);
        res = '0;
        threshold_q = clamp16(longint'(threshold_q) + div_round(longint'(cfg_thr_gain) *
                      (longint'(cfg_base_thr) - longint'(threshold_q)), UNIT));
        if (refr_left != 0)
        begin
            refr_left = refr_left - 16'd1;
            membrane_q = cfg_reset;
            res.refractory = 1'b1;
        end
        else
        begin
            d1 = longint'(cfg_rest) - longint'(membrane_q) + longint'(drv);
            if (cfg_mode == MODE_EULER)
            begin
                membrane_q = clamp16(longint'(membrane_q) + div_round(gain * d1, UNIT));
            end
            else if (cfg_mode == MODE_RK4)
            begin
                d2 = d1 - div_round(gain * d1, 2 * UNIT);
                d3 = d1 - div_round(gain * d2, 2 * UNIT);
                d4 = d1 - div_round(gain * d3, UNIT);
                weighted = d1 + 2 * d2 + 2 * d3 + d4;
                membrane_q = clamp16(longint'(membrane_q) + div_round(gain * weighted, 6 * UNIT));
            end
            if (membrane_q >= threshold_q)
            begin
                res.spiked = 1'b1;
                membrane_q = cfg_reset;
                refr_left = cfg_ticks;
                threshold_q = cfg_peak_thr;
            end
        end
        res.membrane = membrane_q;
        res.threshold = threshold_q;
    endtask

    task automatic write_register(input logic [2:0] index, input logic [15:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {index, 2'b00};
        pwdata = {16'h0000, value};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (index)
            IDX_STEP_GAIN:       cfg_step_gain = value;
            IDX_THR_DECAY_GAIN:  cfg_thr_gain = value;
            IDX_REST_POTENTIAL:  cfg_rest = value;
            IDX_RESET_POTENTIAL: cfg_reset = value;
            IDX_BASE_THRESHOLD:  cfg_base_thr = value;
            IDX_PEAK_THRESHOLD:  cfg_peak_thr = value;
            IDX_REFRACT_TICKS:   cfg_ticks = value;
            IDX_INTEG_MODE:      cfg_mode = value[1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (drive_q.size() != 0 || in_valid || pending_steps.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_phase(input bit wild, input bit last_phase);
        logic signed [15:0] rest;
        logic signed [15:0] base;
        int unsigned        pick;
        if (wild)
        begin
            write_register(IDX_STEP_GAIN, edge_value());
            write_register(IDX_THR_DECAY_GAIN, edge_value());
            write_register(IDX_REST_POTENTIAL, edge_value());
            write_register(IDX_RESET_POTENTIAL, edge_value());
            write_register(IDX_BASE_THRESHOLD, edge_value());
            write_register(IDX_PEAK_THRESHOLD, edge_value());
            write_register(IDX_REFRACT_TICKS,
                           last_phase ? 16'hFFFF : 16'($urandom_range(0, 3)));
            write_register(IDX_INTEG_MODE, 16'($urandom_range(0, 3)));
        end
        else
        begin
            rest = 16'(-int'($urandom_range(15360, 20480)));
            base = rest + 16'($urandom_range(1280, 6400));
            pick = $urandom_range(0, 9);
            write_register(IDX_STEP_GAIN, 16'($urandom_range(1500, 30000)));
            write_register(IDX_THR_DECAY_GAIN, 16'($urandom_range(0, 20000)));
            write_register(IDX_REST_POTENTIAL, rest);
            write_register(IDX_RESET_POTENTIAL, rest - 16'($urandom_range(0, 1280)));
            write_register(IDX_BASE_THRESHOLD, base);
            write_register(IDX_PEAK_THRESHOLD, base + 16'($urandom_range(0, 7680)));
            write_register(IDX_REFRACT_TICKS, 16'($urandom_range(0, 6)));
            if (pick < 4)
            begin
                write_register(IDX_INTEG_MODE, 16'(MODE_EULER));
            end
            else if (pick < 8)
            begin
                write_register(IDX_INTEG_MODE, 16'(MODE_RK4));
            end
            else
            begin
                write_register(IDX_INTEG_MODE, 16'(pick[0] ? MODE_SPARE : MODE_HOLD));
            end
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("leaky_integrate_fire_neuron verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        step_result_t predicted;
        in_fire <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            advance_neuron(drive, predicted);
            pending_steps.push_back(predicted);
            inputs_taken <= inputs_taken + 1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (drive_q.size() != 0)
            begin
                drive <= drive_q.pop_front();
                in_valid <= 1'b1;
                in_gap <= calm_phase ? 0 : idle_span();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!long_hold_done && inputs_taken >= HOLD_AFTER_ITEMS)
            begin
                long_hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0 && !calm_phase)
            begin
                stall_left <= stall_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (!calm_phase && $urandom_range(0, 2) == 0)
                begin
                    stall_left <= idle_span();
                end
                else
                begin
                    stall_left <= 0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        step_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_steps.size() == 0)
            begin
                $error("result transfer with no step pending");
                fail_count++;
            end
            else
            begin
                want = pending_steps.pop_front();
                if (spiked !== want.spiked)
                begin
                    $error("spiked: expected %0d, got %0d", want.spiked, spiked);
                    fail_count++;
                end
                if (membrane_potential !== want.membrane)
                begin
                    $error("membrane_potential: expected %0d, got %0d",
                           $signed(want.membrane), membrane_potential);
                    fail_count++;
                end
                if (current_threshold !== want.threshold)
                begin
                    $error("current_threshold: expected %0d, got %0d",
                           $signed(want.threshold), current_threshold);
                    fail_count++;
                end
                if (refractory_active !== want.refractory)
                begin
                    $error("refractory_active: expected %0d, got %0d",
                           want.refractory, refractory_active);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: drive extremes, a run of strong drive to reach a spike and refractory steps.
        drive_q.push_back(16'sh8000);
        drive_q.push_back(16'sh0000);
        repeat (5) drive_q.push_back(16'sh7FFF);
        drive_q.push_back(-16'sd1);
        drive_q.push_back(16'sd1);
        drive_q.push_back(16'sh5555);
        drive_q.push_back(16'shAAAA);
        drain();

        // Full gain Runge-Kutta with no refractory period and the lowest peak threshold.
        write_register(IDX_STEP_GAIN, 16'hFFFF);
        write_register(IDX_REFRACT_TICKS, 16'h0000);
        write_register(IDX_PEAK_THRESHOLD, 16'h8000);
        write_register(IDX_INTEG_MODE, 16'(MODE_RK4));
        drive_q.push_back(16'sh7FFF);
        drive_q.push_back(16'sh7FFF);
        drive_q.push_back(16'sh8000);
        drive_q.push_back(16'sh8000);
        drive_q.push_back(16'sh0000);
        drive_q.push_back(16'sh7FFF);
        drain();

        // An unused integrator mode skips integration of the membrane.
        write_register(IDX_INTEG_MODE, 16'(MODE_SPARE));
        drive_q.push_back(16'sh7FFF);
        drive_q.push_back(16'sh8000);
        drive_q.push_back(16'sd100);
        drive_q.push_back(-16'sd100);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            bit wild;
            wild = (p % 3 == 2) || (p == RANDOM_PHASES - 1);
            program_phase(wild, p == RANDOM_PHASES - 1);
            calm_phase = (p % 4 == 1);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                drive_q.push_back(random_drive(wild));
            end
            drain();
            calm_phase = 1'b0;
        end

        if (fail_count == 0)
        begin
            $display("leaky_integrate_fire_neuron verification clean");
        end
        else
        begin
            $display("leaky_integrate_fire_neuron verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/lif_pkg.sv
design/lif_cfg.sv
design/lif_mul.sv
design/leaky_integrate_fire_neuron.sv
design/lif_checker.sv
tb/leaky_integrate_fire_neuron_test.sv
